/* src/bsb_pkg.sv */
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types and constants for the bounded-staleness barrier unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsb_pkg;

  localparam int WIDX_W   = 4;
  localparam int ACT_W    = 5;
  localparam int MINR_W   = 5;
  localparam int STALE_W  = 8;
  localparam int PHASE_W  = 16;
  localparam int STEP_W   = 4;
  localparam int SET_W    = 16;
  localparam int OCNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [ACT_W-1:0]   ACTIVE_RST   = 5'd16;
  localparam logic [MINR_W-1:0]  MIN_READY_RST = 5'd1;
  localparam logic [STALE_W-1:0] LIMIT_RST    = 8'd4;
  localparam logic [PHASE_W-1:0] INTERVAL_RST = 16'd0;
  localparam logic [STALE_W-1:0] STALE_MAX    = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE   = 2'd0,
    CFG_MIN_RDY  = 2'd1,
    CFG_LIMIT    = 2'd2,
    CFG_INTERVAL = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Per-lane command from the sequencer to the staleness store.
  typedef struct packed {
    logic upd;
    logic in_set;
  } lane_ctl_t;

endpackage

`default_nettype wire

/* src/bsb_remainder.sv */
// ----------------------------------------------------------------------------
// bsb_remainder
// Bit-serial restoring remainder: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_remainder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bsb_pkg::PHASE_W-1:0] dividend,
  input  wire logic [bsb_pkg::PHASE_W-1:0] divisor,
  output logic                             done,
  output logic [bsb_pkg::PHASE_W-1:0]      rem
);
  import bsb_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [PHASE_W-1:0]  quo_r, quo_nxt;
  logic [PHASE_W-1:0]  rem_r, rem_nxt;
  logic [PHASE_W:0]    trial;
  logic [PHASE_W:0]    diff;

  always_comb begin
    trial    = {rem_r, quo_r[PHASE_W-1]};
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // A clear top bit of the difference means the trial value covered the divisor.
      rem_nxt  = diff[PHASE_W] ? trial[PHASE_W-1:0] : diff[PHASE_W-1:0];
      quo_nxt  = {quo_r[PHASE_W-2:0], 1'b0};
      step_nxt = step_r + 1'b1;
      if (step_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

/* src/bsb_stale_store.sv */
// ----------------------------------------------------------------------------
// bsb_stale_store
// Per-worker staleness counters with one shared compare and update path.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_stale_store #(
  parameter int MAX_WORKERS = 16,
  parameter int LI_W        = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [LI_W-1:0]             lane_idx,
  input  wire bsb_pkg::lane_ctl_t          lane_ctl,
  input  wire logic [bsb_pkg::STALE_W-1:0] limit,
  output logic                             stale_hit
);
  import bsb_pkg::*;

  logic [STALE_W-1:0] stale_r [MAX_WORKERS];
  logic [STALE_W-1:0] cur;
  logic [STALE_W-1:0] upd_val;

  always_comb begin
    cur       = stale_r[lane_idx];
    stale_hit = (cur >= limit);
    if (lane_ctl.in_set) begin
      upd_val = '0;
    end else if (cur == STALE_MAX) begin
      upd_val = cur;
    end else begin
      upd_val = cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_WORKERS; i++) begin
        stale_r[i] <= '0;
      end
    end else if (lane_ctl.upd) begin
      stale_r[lane_idx] <= upd_val;
    end
  end

endmodule

`default_nettype wire

/* src/bounded_staleness_barrier_unit.sv */
// ----------------------------------------------------------------------------
// bounded_staleness_barrier_unit
// Partial barrier with bounded staleness and periodic full-sync rounds.
// ----------------------------------------------------------------------------
// An accepted event passes the remainder step and the staleness scan, plus
// the staleness update pass when it fires a round, before its word is output.
// No new event is taken until that result word has been loaded into the
// output register; the bit-serial remainder of the round counter and the
// one-lane-per-cycle staleness pass set the pace.
// Reset (rst_n low, synchronous): ready set, staleness counters and round
// counter clear; registers take their documented reset values.
`default_nettype none

module bounded_staleness_barrier_unit #(
  parameter int MAX_WORKERS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: [3:0] worker_index, [7:4] zero
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [bsb_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [0] fired, [16:1] ready_set, [21:17] ready_count,
  // [22] full_round, [23] zero
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [bsb_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                           cfg_wr_en,
  input  wire logic [bsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bsb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bsb_pkg::*;

  localparam int LI_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW   = $clog2(MAX_WORKERS + 1);
  localparam int AW   = (NW > ACT_W) ? NW : ACT_W;

  // Configuration registers.
  logic [ACT_W-1:0]   cfg_active_r;
  logic [MINR_W-1:0]  cfg_min_r;
  logic [STALE_W-1:0] cfg_limit_r;
  logic [PHASE_W-1:0] cfg_interval_r;

  state_t                 state_r, state_nxt;
  logic [MAX_WORKERS-1:0] ready_r, ready_nxt;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic [LI_W-1:0]        lane_r, lane_nxt;
  logic [NW-1:0]          cnt_r, cnt_nxt;
  logic                   blk_r, blk_nxt;
  logic                   new_r, new_nxt;
  logic                   full_r, full_nxt;
  logic                   res_fired_r, res_fired_nxt;
  logic [SET_W-1:0]       res_set_r, res_set_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  logic [AW-1:0]          eff_ext;
  logic [NW-1:0]          eff_n;
  logic [MAX_WORKERS-1:0] act_mask;
  logic [WIDX_W-1:0]      in_widx;
  logic [LI_W-1:0]        in_lane;
  logic                   in_acc;
  logic                   lane_act;
  logic                   lane_in_set;
  logic                   last_lane;
  logic [NW-1:0]          cnt_fin;
  logic                   blk_fin;
  logic                   round_ok;
  logic                   rem_done;
  logic [PHASE_W-1:0]     rem_val;
  logic                   stale_hit;
  lane_ctl_t              lane_ctl;

  // Effective worker count and lane mask.
  always_comb begin
    if (AW'(cfg_active_r) > AW'(MAX_WORKERS)) begin
      eff_ext = AW'(MAX_WORKERS);
    end else begin
      eff_ext = AW'(cfg_active_r);
    end
    eff_n = NW'(eff_ext);
    for (int i = 0; i < MAX_WORKERS; i++) begin
      act_mask[i] = (AW'(i) < eff_ext);
    end
  end

  assign in_widx     = in_tdata[WIDX_W-1:0];
  assign in_lane     = LI_W'(in_widx);
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign lane_act    = (AW'(lane_r) < eff_ext);
  assign lane_in_set = ready_r[lane_r] & lane_act;
  assign last_lane   = (lane_r == LI_W'(MAX_WORKERS - 1));
  assign cnt_fin     = cnt_r + NW'(lane_in_set);
  assign blk_fin     = blk_r | (lane_act & ~lane_in_set & stale_hit);

  always_comb begin
    if (full_r) begin
      round_ok = (cnt_fin == eff_n);
    end else begin
      round_ok = (AW'(cnt_fin) >= AW'(cfg_min_r)) && !blk_fin;
    end
  end

  bsb_remainder u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .dividend (phase_r),
    .divisor  (cfg_interval_r),
    .done     (rem_done),
    .rem      (rem_val)
  );

  bsb_stale_store #(
    .MAX_WORKERS (MAX_WORKERS),
    .LI_W        (LI_W)
  ) u_stale (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_idx  (lane_r),
    .lane_ctl  (lane_ctl),
    .limit     (cfg_limit_r),
    .stale_hit (stale_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    ready_nxt     = ready_r;
    phase_nxt     = phase_r;
    lane_nxt      = lane_r;
    cnt_nxt       = cnt_r;
    blk_nxt       = blk_r;
    new_nxt       = new_r;
    full_nxt      = full_r;
    res_fired_nxt = res_fired_r;
    res_set_nxt   = res_set_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    lane_ctl.upd    = 1'b0;
    lane_ctl.in_set = lane_in_set;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // A new ready only counts from an active worker not yet in the set.
          new_nxt = (AW'(in_widx) < eff_ext) && !ready_r[in_lane];
          if (new_nxt) begin
            ready_nxt[in_lane] = 1'b1;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          full_nxt  = (cfg_interval_r != '0) && (rem_val == '0);
          lane_nxt  = '0;
          cnt_nxt   = '0;
          blk_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_fin;
        blk_nxt = blk_fin;
        if (last_lane) begin
          res_fired_nxt = new_r && round_ok;
          res_set_nxt   = (new_r && round_ok) ? SET_W'(ready_r & act_mask) : '0;
          lane_nxt      = '0;
          state_nxt     = (new_r && round_ok) ? ST_UPDATE : ST_EMIT;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        lane_ctl.upd = lane_act;
        if (last_lane) begin
          ready_nxt = '0;
          phase_nxt = phase_r + 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          lane_nxt = lane_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, full_r, OCNT_W'(cnt_r), res_set_r, res_fired_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ready_r     <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lane_r      <= lane_nxt;
    cnt_r       <= cnt_nxt;
    blk_r       <= blk_nxt;
    new_r       <= new_nxt;
    full_r      <= full_nxt;
    res_fired_r <= res_fired_nxt;
    res_set_r   <= res_set_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r   <= ACTIVE_RST;
      cfg_min_r      <= MIN_READY_RST;
      cfg_limit_r    <= LIMIT_RST;
      cfg_interval_r <= INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ACTIVE:   cfg_active_r   <= cfg_wdata[ACT_W-1:0];
        CFG_MIN_RDY:  cfg_min_r      <= cfg_wdata[MINR_W-1:0];
        CFG_LIMIT:    cfg_limit_r    <= cfg_wdata[STALE_W-1:0];
        CFG_INTERVAL: cfg_interval_r <= cfg_wdata[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The round counter only moves at the end of a staleness update pass.
  a_phase_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_UPDATE) |=> $stable(phase_r))
    else $error("round counter changed outside the update pass");

  // The remainder unit finishes only while the sequencer waits for it.
  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == ST_DIV))
    else $error("remainder result arrived outside the divide step");

  // An accepted event always starts the remainder step.
  a_accept_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV))
    else $error("accepted event did not start the divide step");

  // A word that did not fire a round reports an empty ready set.
  a_no_fire_empty_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r[0]) |-> (out_data_r[SET_W:1] == '0))
    else $error("ready set reported without a firing");

endmodule

`default_nettype wire
